// ===== sv/cmd_pkg.sv =====
// Shared types, codes and elaboration-time helpers for the column destriping block.
// No dependencies; every other file of the block imports this package.
package cmd_pkg;

    localparam int WIDTH_MAX_DEF        = 64;
    localparam int HEIGHT_MAX_DEF       = 64;
    localparam int SIGMA_QUARTERS_DEF   = 4;
    localparam int WEIGHT_FRAC_BITS_DEF = 15;

    localparam int PIX_W = 16;
    localparam int DIM_W = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             not_ready;
        logic             last;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_COUNT,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDATA,
        S_SA_FEED,
        S_SA_WAIT,
        S_SA_DUMP,
        S_TGT,
        S_TGT_WAIT,
        S_B_FEED,
        S_B_WAIT,
        S_COUNT,
        S_CLEAR
    } t_state;

    // Shift-subtract division, used only for constants at elaboration.
    function automatic longint unsigned cmd_udiv(input longint unsigned a,
                                                 input longint unsigned b);
        longint unsigned qv;
        longint unsigned rv;
        qv = 0;
        rv = 0;
        for (int i = 63; i >= 0; i--) begin
            rv = {rv[62:0], a[i]};
            if (rv >= b) begin
                rv = rv - b;
                qv[i] = 1'b1;
            end
        end
        return qv;
    endfunction

    // Gaussian weight for column distance d, Q.f, with sigma = q/4.
    function automatic longint unsigned cmd_gauss_weight(input int unsigned d,
                                                         input int unsigned q,
                                                         input int unsigned f);
        longint unsigned t;
        longint unsigned e;
        longint unsigned term;
        longint unsigned den;
        longint unsigned dd;
        longint unsigned qq;
        dd   = d;
        qq   = q;
        t    = cmd_udiv((dd * dd) << 29, qq * qq);
        e    = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            term = cmd_udiv((term * t) >> 30, longint'(k));
            if (k % 2 == 1) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        for (int i = 0; i < 4; i++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        e   = (e * 64'd428361012 + (64'd1 << 29)) >> 30;
        den = qq << (30 - f);
        return cmd_udiv(e * 4 + (den >> 1), den);
    endfunction

endpackage

// ===== sv/cmd_cell.sv =====
// One cell of the column chain: insertion sort, shift-out and rank counting.
// Depends on cmd_pkg for the cell operation codes.
module cmd_cell #(
    parameter int CNT_W = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cmd_pkg::t_cell_op        i_op,
    input  logic                     i_in_vld,
    input  logic [cmd_pkg::PIX_W-1:0] i_in_val,
    input  logic [CNT_W-1:0]         i_in_cnt,
    input  logic                     i_nb_vld,
    input  logic [cmd_pkg::PIX_W-1:0] i_nb_val,
    output logic                     o_out_vld,
    output logic [cmd_pkg::PIX_W-1:0] o_out_val,
    output logic [CNT_W-1:0]         o_out_cnt,
    output logic                     o_vld,
    output logic [cmd_pkg::PIX_W-1:0] o_val
);
    import cmd_pkg::*;

    logic             r_vld;
    logic [PIX_W-1:0] r_val;
    logic             r_pvld;
    logic [PIX_W-1:0] r_pval;
    logic [CNT_W-1:0] r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= 1'b0;
            unique case (i_op)
                CELL_CLEAR: begin
                    r_vld <= 1'b0;
                end
                CELL_INSERT: begin
                    if (i_in_vld) begin
                        if (!r_vld) begin
                            r_vld <= 1'b1;
                            r_val <= i_in_val;
                        end else if (i_in_val < r_val) begin
                            // keep the smaller, pass the larger on
                            r_val  <= i_in_val;
                            r_pval <= r_val;
                            r_pvld <= 1'b1;
                        end else begin
                            r_pval <= i_in_val;
                            r_pvld <= 1'b1;
                        end
                    end
                end
                CELL_SHIFT: begin
                    r_vld <= i_nb_vld;
                    r_val <= i_nb_val;
                end
                CELL_COUNT: begin
                    r_pvld <= i_in_vld;
                    r_pval <= i_in_val;
                    r_pcnt <= i_in_cnt + CNT_W'(r_vld && (r_val <= i_in_val));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_vld = r_pvld;
    assign o_out_val = r_pval;
    assign o_out_cnt = r_pcnt;
    assign o_vld     = r_vld;
    assign o_val     = r_val;

endmodule

// ===== sv/cmd_chain.sv =====
// Row of cmd_cell instances holding one image column.
// Depends on cmd_pkg and cmd_cell.
module cmd_chain #(
    parameter int DEPTH = 64,
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cmd_pkg::t_cell_op         i_op,
    input  logic                      i_feed_vld,
    input  logic [cmd_pkg::PIX_W-1:0] i_feed_val,
    output logic [cmd_pkg::PIX_W-1:0] o_head_val,
    output logic                      o_tail_vld,
    output logic [CNT_W-1:0]          o_tail_cnt
);
    import cmd_pkg::*;

    logic             in_vld [DEPTH];
    logic [PIX_W-1:0] in_val [DEPTH];
    logic [CNT_W-1:0] in_cnt [DEPTH];
    logic             nb_vld [DEPTH];
    logic [PIX_W-1:0] nb_val [DEPTH];
    logic             p_vld  [DEPTH];
    logic [PIX_W-1:0] p_val  [DEPTH];
    logic [CNT_W-1:0] p_cnt  [DEPTH];
    logic             h_vld  [DEPTH];
    logic [PIX_W-1:0] h_val  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign in_vld[g] = i_feed_vld;
            assign in_val[g] = i_feed_val;
            assign in_cnt[g] = '0;
        end else begin : g_rest
            assign in_vld[g] = p_vld[g-1];
            assign in_val[g] = p_val[g-1];
            assign in_cnt[g] = p_cnt[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign nb_vld[g] = 1'b0;
            assign nb_val[g] = '0;
        end else begin : g_mid
            assign nb_vld[g] = h_vld[g+1];
            assign nb_val[g] = h_val[g+1];
        end
        cmd_cell #(.CNT_W(CNT_W)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (i_op),
            .i_in_vld  (in_vld[g]),
            .i_in_val  (in_val[g]),
            .i_in_cnt  (in_cnt[g]),
            .i_nb_vld  (nb_vld[g]),
            .i_nb_val  (nb_val[g]),
            .o_out_vld (p_vld[g]),
            .o_out_val (p_val[g]),
            .o_out_cnt (p_cnt[g]),
            .o_vld     (h_vld[g]),
            .o_val     (h_val[g])
        );
    end

    assign o_head_val = h_val[0];
    assign o_tail_vld = p_vld[DEPTH-1];
    assign o_tail_cnt = p_cnt[DEPTH-1];

endmodule

// ===== sv/cmd_wsum.sv =====
// Gaussian-weighted sum over neighbor columns, one product per cycle.
// Depends on cmd_pkg for the weight function; sorted data arrives in the cycle after issue.
module cmd_wsum #(
    parameter int SIGMA_QUARTERS   = 4,
    parameter int WEIGHT_FRAC_BITS = 15,
    parameter int KW               = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic                                   i_first,
    input  logic                                   i_last,
    input  logic [$clog2(SIGMA_QUARTERS+1)-1:0]    i_wi,
    input  logic [KW-1:0]                          i_k,
    input  logic [cmd_pkg::PIX_W-1:0]              i_data,
    output logic                                   o_we,
    output logic [KW-1:0]                          o_k,
    output logic [cmd_pkg::PIX_W-1:0]              o_val
);
    import cmd_pkg::*;

    localparam int N  = SIGMA_QUARTERS;
    localparam int F  = WEIGHT_FRAC_BITS;
    localparam int DW = $clog2(N + 1);
    localparam int WW = F + 2;
    localparam int PW = PIX_W + WW;
    localparam int AW = PW + $clog2(2 * N + 1);

    logic [WW-1:0] w_tab [N+1];

    for (genvar g = 0; g <= N; g++) begin : g_wt
        localparam longint unsigned WV = cmd_gauss_weight(g, N, F);
        assign w_tab[g] = WW'(WV);
    end

    logic          r_s1_vld, r_s1_first, r_s1_last;
    logic [DW-1:0] r_s1_wi;
    logic [KW-1:0] r_s1_k;
    logic          r_s2_vld, r_s2_first, r_s2_last;
    logic [KW-1:0] r_s2_k;
    logic [PW-1:0] r_s2_prod;
    logic          r_s3_vld, r_s3_last;
    logic [KW-1:0] r_s3_k;
    logic [AW-1:0] r_acc;
    logic [AW:0]   rnd;
    logic [AW:0]   qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_first;
        r_s1_last  <= i_last;
        r_s1_wi    <= i_wi;
        r_s1_k     <= i_k;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_k     <= r_s1_k;
        r_s2_prod  <= PW'(i_data) * PW'(w_tab[r_s1_wi]);
        r_s3_last  <= r_s2_last;
        r_s3_k     <= r_s2_k;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? AW'(r_s2_prod) : r_acc + AW'(r_s2_prod);
        end
    end

    // round to nearest, drop the fraction, clip at full scale
    assign rnd   = (AW+1)'(r_acc) + (AW+1)'(1 << (F - 1));
    assign qv    = rnd >> F;
    assign o_val = (qv > (AW+1)'(16'hFFFF)) ? 16'hFFFF : qv[PIX_W-1:0];
    assign o_we  = r_s3_vld && r_s3_last;
    assign o_k   = r_s3_k;

endmodule

// ===== sv/column_midway_destripe_core.sv =====
// Column destriping core: frame store, column sort, target build and remap.
// Depends on cmd_pkg, cmd_chain (cmd_cell) and cmd_wsum.
//
// Load a frame of rows x cols pixels in row-major order (op 0), one transfer
// per cycle while no register write is offered. The last pixel starts
// processing, during which no item is taken: per column, h reads into the cell
// chain, a settling wait and the unload of the sorted column; then per
// processed column the weighted sums through the single multiplier, a reload
// of the chain, the rank search and a clear. Reads (op 1) go through the
// registered frame memory port, and the next read is taken only after the
// previous pixel is returned; a read before the frame is complete returns
// not_ready. Loads are taken while a result waits.
module column_midway_destripe_core #(
    parameter int WIDTH_MAX        = cmd_pkg::WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX       = cmd_pkg::HEIGHT_MAX_DEF,
    parameter int SIGMA_QUARTERS   = cmd_pkg::SIGMA_QUARTERS_DEF,
    parameter int WEIGHT_FRAC_BITS = cmd_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [cmd_pkg::DIM_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cmd_pkg::t_in_item         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cmd_pkg::t_out_item        o_out
);
    import cmd_pkg::*;

    localparam int N    = SIGMA_QUARTERS;
    localparam int IAW  = $clog2(WIDTH_MAX * HEIGHT_MAX);
    localparam int TW   = $clog2(WIDTH_MAX * HEIGHT_MAX + 1);
    localparam int CW   = $clog2(WIDTH_MAX + 1);
    localparam int HW   = $clog2(HEIGHT_MAX + 1);
    localparam int KW   = $clog2(HEIGHT_MAX);
    localparam int CIW  = $clog2(WIDTH_MAX);
    localparam int SAW  = CIW + KW;
    localparam int JW   = $clog2(2 * N + 1);
    localparam int DW   = $clog2(N + 1);
    localparam int WTW  = $clog2(HEIGHT_MAX + 3);
    localparam int IMG_DEPTH = WIDTH_MAX * HEIGHT_MAX;
    localparam int SRT_DEPTH = WIDTH_MAX << KW;

    // memories
    logic [PIX_W-1:0] img_mem [IMG_DEPTH];
    logic [PIX_W-1:0] srt_mem [SRT_DEPTH];
    logic [PIX_W-1:0] tgt_mem [HEIGHT_MAX];

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_cols, n_cols, r_rows, n_rows;
    logic [TW-1:0]    r_load_cnt, n_load_cnt, r_read_cnt, n_read_cnt;
    logic             r_ready, n_ready;
    logic [CW-1:0]    r_c, n_c;
    logic [HW-1:0]    r_r, n_r;
    logic [HW-1:0]    r_wrows, n_wrows;
    logic [IAW-1:0]   r_addr, n_addr, r_waddr, n_waddr;
    logic [KW-1:0]    r_k, n_k;
    logic [JW-1:0]    r_j, n_j;
    logic [WTW-1:0]   r_wait, n_wait;
    logic             r_feed_vld, n_feed_vld;
    logic             r_trd_vld;
    logic             r_rd_last, n_rd_last;
    logic             r_out_vld, n_out_vld;
    t_out_item        r_out, n_out;

    logic [PIX_W-1:0] r_img_q, r_srt_q, r_tgt_q;

    logic [CW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [CW+HW-1:0] prod;
    logic [TW-1:0]    total;
    logic [TW-1:0]    lc;

    logic             img_we;
    logic [IAW-1:0]   img_waddr, img_raddr;
    logic [PIX_W-1:0] img_wdata;
    logic             srt_we;
    logic [SAW-1:0]   srt_waddr, srt_raddr;

    t_cell_op         cop;
    logic [PIX_W-1:0] head_val;
    logic             tail_vld;
    logic [HW-1:0]    tail_cnt;
    logic [KW-1:0]    tgt_raddr;

    logic             ws_vld, ws_first, ws_last;
    logic [DW-1:0]    ws_wi;
    logic             ws_we;
    logic [KW-1:0]    ws_k;
    logic [PIX_W-1:0] ws_val;

    logic             acc_in, acc_out;

    assign w_eff = (r_cols == '0) ? CW'(1)
                 : (int'(r_cols) > WIDTH_MAX) ? CW'(WIDTH_MAX) : CW'(r_cols);
    assign h_eff = (r_rows == '0) ? HW'(1)
                 : (int'(r_rows) > HEIGHT_MAX) ? HW'(HEIGHT_MAX) : HW'(r_rows);
    assign prod  = w_eff * h_eff;
    assign total = TW'(prod);
    assign lc    = (r_ready || r_load_cnt >= total) ? '0 : r_load_cnt;

    // hold register writes and items off while the frame is being processed
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid
                      && !(r_out_vld && !i_out_ready && (i_in.op == OP_READ));
    assign acc_in      = i_in_valid && o_in_ready;
    assign acc_out     = r_out_vld && i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign img_raddr = (r_state == S_IDLE) ? IAW'(r_read_cnt) : r_addr;
    assign tgt_raddr = KW'(tail_cnt - HW'(1));

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            img_mem[img_waddr] <= img_wdata;
        end
        r_img_q <= img_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            srt_mem[srt_waddr] <= head_val;
        end
        r_srt_q <= srt_mem[srt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            tgt_mem[ws_k] <= ws_val;
        end
        r_tgt_q <= tgt_mem[tgt_raddr];
    end

    cmd_chain #(.DEPTH(HEIGHT_MAX), .CNT_W(HW)) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (cop),
        .i_feed_vld (r_feed_vld),
        .i_feed_val (r_img_q),
        .o_head_val (head_val),
        .o_tail_vld (tail_vld),
        .o_tail_cnt (tail_cnt)
    );

    cmd_wsum #(
        .SIGMA_QUARTERS   (SIGMA_QUARTERS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .KW               (KW)
    ) u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (ws_vld),
        .i_first (ws_first),
        .i_last  (ws_last),
        .i_wi    (ws_wi),
        .i_k     (r_k),
        .i_data  (r_srt_q),
        .o_we    (ws_we),
        .o_k     (ws_k),
        .o_val   (ws_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cols     <= DIM_W'(64);
            r_rows     <= DIM_W'(64);
            r_load_cnt <= '0;
            r_read_cnt <= '0;
            r_ready    <= 1'b0;
            r_feed_vld <= 1'b0;
            r_trd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cols     <= n_cols;
            r_rows     <= n_rows;
            r_load_cnt <= n_load_cnt;
            r_read_cnt <= n_read_cnt;
            r_ready    <= n_ready;
            r_feed_vld <= n_feed_vld;
            r_trd_vld  <= tail_vld && (r_state == S_COUNT);
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c       <= n_c;
        r_r       <= n_r;
        r_wrows   <= n_wrows;
        r_addr    <= n_addr;
        r_waddr   <= n_waddr;
        r_k       <= n_k;
        r_j       <= n_j;
        r_wait    <= n_wait;
        r_rd_last <= n_rd_last;
        r_out     <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_cols     = r_cols;
        n_rows     = r_rows;
        n_load_cnt = r_load_cnt;
        n_read_cnt = r_read_cnt;
        n_ready    = r_ready;
        n_c        = r_c;
        n_r        = r_r;
        n_wrows    = r_wrows;
        n_addr     = r_addr;
        n_waddr    = r_waddr;
        n_k        = r_k;
        n_j        = r_j;
        n_wait     = r_wait;
        n_rd_last  = r_rd_last;
        n_feed_vld = 1'b0;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !acc_out;
        img_we     = 1'b0;
        img_waddr  = IAW'(lc);
        img_wdata  = i_in.pixel_in;
        srt_we     = 1'b0;
        srt_waddr  = {r_c[CIW-1:0], r_r[KW-1:0]};
        srt_raddr  = {CIW'(int'(r_c) - N + int'(r_j)), r_k};
        cop        = CELL_HOLD;
        ws_vld     = 1'b0;
        ws_first   = (r_j == '0);
        ws_last    = (int'(r_j) == 2 * N);
        ws_wi      = DW'((int'(r_j) >= N) ? int'(r_j) - N : N - int'(r_j));

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // a register write abandons the frame
                    if (i_cfg_index == CFG_COLS) begin
                        n_cols = i_cfg_data;
                    end else begin
                        n_rows = i_cfg_data;
                    end
                    n_load_cnt = '0;
                    n_read_cnt = '0;
                    n_ready    = 1'b0;
                end else if (acc_in) begin
                    if (i_in.op == OP_LOAD) begin
                        img_we     = 1'b1;
                        n_load_cnt = lc + TW'(1);
                        n_ready    = 1'b0;
                        n_read_cnt = '0;
                        if (lc + TW'(1) == total) begin
                            n_state = S_SA_FEED;
                            n_c     = '0;
                            n_r     = '0;
                            n_addr  = '0;
                        end
                    end else if (!r_ready) begin
                        n_out     = '{pixel_out: '0, not_ready: 1'b1, last: 1'b0};
                        n_out_vld = 1'b1;
                    end else begin
                        n_rd_last = (r_read_cnt + TW'(1) == total);
                        n_state   = S_RDATA;
                        if (r_read_cnt + TW'(1) == total) begin
                            n_read_cnt = '0;
                            n_load_cnt = '0;
                            n_ready    = 1'b0;
                        end else begin
                            n_read_cnt = r_read_cnt + TW'(1);
                        end
                    end
                end
            end
            S_RDATA: begin
                n_out     = '{pixel_out: r_img_q, not_ready: 1'b0, last: r_rd_last};
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_SA_FEED, S_B_FEED: begin
                cop        = CELL_INSERT;
                n_feed_vld = 1'b1;
                n_addr     = r_addr + IAW'(w_eff);
                n_r        = r_r + HW'(1);
                if (r_r == h_eff - HW'(1)) begin
                    n_state = (r_state == S_SA_FEED) ? S_SA_WAIT : S_B_WAIT;
                    n_wait  = '0;
                end
            end
            S_SA_WAIT, S_B_WAIT: begin
                cop    = CELL_INSERT;
                n_wait = r_wait + WTW'(1);
                if (int'(r_wait) == HEIGHT_MAX + 1) begin
                    n_r = '0;
                    if (r_state == S_SA_WAIT) begin
                        n_state = S_SA_DUMP;
                    end else begin
                        n_state = S_COUNT;
                        n_addr  = IAW'(r_c);
                        n_waddr = IAW'(r_c);
                        n_wrows = '0;
                    end
                end
            end
            S_SA_DUMP: begin
                // write the head, then advance the column toward it
                cop    = CELL_SHIFT;
                srt_we = 1'b1;
                n_r    = r_r + HW'(1);
                if (r_r == h_eff - HW'(1)) begin
                    n_r = '0;
                    if (r_c + CW'(1) == w_eff) begin
                        if (int'(w_eff) >= 2 * N + 1) begin
                            n_state = S_TGT;
                            n_c     = CW'(N);
                            n_j     = '0;
                            n_k     = '0;
                        end else begin
                            n_state    = S_IDLE;
                            n_ready    = 1'b1;
                            n_read_cnt = '0;
                        end
                    end else begin
                        n_c     = r_c + CW'(1);
                        n_addr  = IAW'(r_c + CW'(1));
                        n_state = S_SA_FEED;
                    end
                end
            end
            S_TGT: begin
                ws_vld = 1'b1;
                if (int'(r_j) == 2 * N) begin
                    n_j = '0;
                    if (HW'(r_k) == h_eff - HW'(1)) begin
                        n_state = S_TGT_WAIT;
                        n_wait  = '0;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_TGT_WAIT: begin
                n_wait = r_wait + WTW'(1);
                if (r_wait == WTW'(5)) begin
                    n_state = S_B_FEED;
                    n_r     = '0;
                    n_addr  = IAW'(r_c);
                end
            end
            S_COUNT: begin
                cop = CELL_COUNT;
                if (r_r < h_eff) begin
                    n_feed_vld = 1'b1;
                    n_addr     = r_addr + IAW'(w_eff);
                    n_r        = r_r + HW'(1);
                end
                if (r_trd_vld) begin
                    img_we    = 1'b1;
                    img_waddr = r_waddr;
                    img_wdata = r_tgt_q;
                    n_waddr   = r_waddr + IAW'(w_eff);
                    n_wrows   = r_wrows + HW'(1);
                end
                if (r_wrows == h_eff) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cop = CELL_CLEAR;
                if (int'(r_c) + N + 1 < int'(w_eff)) begin
                    n_c     = r_c + CW'(1);
                    n_j     = '0;
                    n_k     = '0;
                    n_state = S_TGT;
                end else begin
                    n_state    = S_IDLE;
                    n_ready    = 1'b1;
                    n_read_cnt = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
